/* hw/rtl/xmt_pkg.sv */
// Shared codes and types for the XML markup tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package xmt_pkg;

  // Scanner modes
  localparam logic [2:0] MODE_TEXT   = 3'd0;
  localparam logic [2:0] MODE_TAG    = 3'd1;
  localparam logic [2:0] MODE_ATTR   = 3'd2;
  localparam logic [2:0] MODE_VALSQ  = 3'd3;
  localparam logic [2:0] MODE_VALDQ  = 3'd4;
  localparam logic [2:0] MODE_ENDTAG = 3'd5;

  // Byte classes
  localparam logic [2:0] KIND_SKIP   = 3'd0;
  localparam logic [2:0] KIND_TEXT   = 3'd1;
  localparam logic [2:0] KIND_TAG    = 3'd2;
  localparam logic [2:0] KIND_ATTR   = 3'd3;
  localparam logic [2:0] KIND_VAL    = 3'd4;
  localparam logic [2:0] KIND_ENDTAG = 3'd5;

  // Events
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_TEXT  = 3'd1;
  localparam logic [2:0] EV_START = 3'd2;
  localparam logic [2:0] EV_END   = 3'd3;
  localparam logic [2:0] EV_ATTR  = 3'd4;

  // Characters
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0] mode;
    logic       pending;
    logic [7:0] count;
  } scan_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] ev;
    logic [7:0] len;
  } scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/xml_markup_tokenizer.sv */
// Top level of the XML markup tokenizer: input register, scanner, result register.
// A transferred byte waits in the input register, then moves with its result into the result register.
// Throughput: one byte per clock unless the output stalls; the state register loops through the scanner.
// The input register holds one byte while a finished result waits on a stalled output.
// Reset clears both valid flags and puts the scanner in text mode with the count at zero.
// Payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module xml_markup_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       chunk_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [2:0] byte_kind_o,
  output logic [2:0] event_res_o,
  output logic [7:0] name_length_o,
  output logic       chunk_end_o
);
  import xmt_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        advance;

  scan_state_t state_q, state_d;
  scan_res_t   res_d, res_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  // Result register frees up when empty or when its transfer completes
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= byte_in_i;
      in_last_q <= chunk_last_i;
    end
  end

  xmt_scan u_scan (
    .byte_i  (in_byte_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{mode: MODE_TEXT, pending: 1'b0, count: 8'd0};
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q      <= res_d;
      out_byte_q <= in_byte_q;
      out_last_q <= in_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = out_byte_q;
  assign byte_kind_o   = res_q.kind;
  assign event_res_o   = res_q.ev;
  assign name_length_o = res_q.len;
  assign chunk_end_o   = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/xmt_scan.sv */
// Combinational scanner step: classifies one byte and computes the next state.
`timescale 1ns / 1ps
`default_nettype none

module xmt_scan (
  input  logic [7:0]           byte_i,
  input  xmt_pkg::scan_state_t state_i,
  output xmt_pkg::scan_state_t state_o,
  output xmt_pkg::scan_res_t   res_o
);
  import xmt_pkg::*;

  logic [7:0] count_inc;
  logic       tag_like;

  assign count_inc = (state_i.count != COUNT_MAX) ? state_i.count + 8'd1 : state_i.count;

  // Bracket and slash inside the attribute list behave as in the tag name
  assign tag_like = (state_i.mode == MODE_TAG) ||
                    ((state_i.mode == MODE_ATTR) && ((byte_i == CH_GT) || (byte_i == CH_SLASH)));

  always_comb begin
    state_o = state_i;
    res_o   = '{kind: KIND_SKIP, ev: EV_NONE, len: 8'd0};
    if (tag_like) begin
      state_o.mode = MODE_TAG;
      if (byte_i == CH_QMARK) begin
        // skip
      end else if (byte_i == CH_SLASH) begin
        state_o.mode = MODE_ENDTAG;
        if (state_i.count != 8'd0) begin
          res_o.ev  = EV_START;
          res_o.len = state_i.count;
        end
      end else if (byte_i == CH_SPACE) begin
        state_o.mode = MODE_ATTR;
      end else if (byte_i == CH_GT) begin
        state_o.mode = MODE_TEXT;
        res_o.ev     = EV_START;
        res_o.len    = state_i.count;
      end else begin
        state_o.count = count_inc;
        res_o.kind    = KIND_TAG;
      end
    end else begin
      case (state_i.mode)
        MODE_ATTR: begin
          if ((byte_i == CH_QMARK) || (byte_i == CH_SPACE) || (byte_i == CH_EQ)) begin
            // skip
          end else if (byte_i == CH_SQUOTE) begin
            state_o.mode = MODE_VALSQ;
          end else if (byte_i == CH_DQUOTE) begin
            state_o.mode = MODE_VALDQ;
          end else begin
            res_o.kind = KIND_ATTR;
          end
        end
        MODE_VALSQ: begin
          if (byte_i == CH_SQUOTE) begin
            state_o.mode = MODE_ATTR;
            res_o.ev     = EV_ATTR;
          end else begin
            res_o.kind = KIND_VAL;
          end
        end
        MODE_VALDQ: begin
          if (byte_i == CH_DQUOTE) begin
            state_o.mode = MODE_ATTR;
            res_o.ev     = EV_ATTR;
          end else begin
            res_o.kind = KIND_VAL;
          end
        end
        MODE_ENDTAG: begin
          if (byte_i == CH_SPACE) begin
            // skip
          end else if (byte_i == CH_GT) begin
            state_o.mode = MODE_TEXT;
            res_o.ev     = EV_END;
            res_o.len    = state_i.count;
          end else begin
            state_o.count = count_inc;
            res_o.kind    = KIND_ENDTAG;
          end
        end
        default: begin
          // text mode; unused codes fall back to text
          state_o.mode = MODE_TEXT;
          if (byte_i == CH_LT) begin
            state_o.mode    = MODE_TAG;
            state_o.pending = 1'b0;
            state_o.count   = 8'd0;
            if (state_i.pending) res_o.ev = EV_TEXT;
          end else begin
            state_o.pending = 1'b1;
            res_o.kind      = KIND_TEXT;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xmt_chk.sv */
// Port-level checker for the XML markup tokenizer and its bind.
`timescale 1ns / 1ps
`default_nettype none

module xmt_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] byte_out_o,
  input wire logic [2:0] byte_kind_o,
  input wire logic [2:0] event_res_o,
  input wire logic [7:0] name_length_o
);
  import xmt_pkg::*;

  // A classified byte never carries an event
  a_kind_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (byte_kind_o != KIND_SKIP)) |-> (event_res_o == EV_NONE))
    else $error("classified byte carries an event");

  // Name length only shows on tag events
  a_len_on_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (name_length_o != 8'd0)) |->
      ((event_res_o == EV_START) || (event_res_o == EV_END)))
    else $error("name length outside a tag event");

  // Text ends only at an opening bracket, an end tag only at a closing one
  a_text_at_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_TEXT)) |-> (byte_out_o == CH_LT))
    else $error("text done not at opening bracket");

  a_end_at_gt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_END)) |-> (byte_out_o == CH_GT))
    else $error("tag end not at closing bracket");

  // Hold the result while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(byte_out_o) && $stable(event_res_o)))
    else $error("stalled result changed");

endmodule

bind xml_markup_tokenizer xmt_chk u_xmt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .byte_out_o    (byte_out_o),
  .byte_kind_o   (byte_kind_o),
  .event_res_o   (event_res_o),
  .name_length_o (name_length_o)
);

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the XML markup tokenizer: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb;
  import xmt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;   // hold this byte until every result is back
  } markup_byte_t;

  typedef struct packed {
    logic [7:0] data;
    scan_res_t  res;
    logic       last;
  } token_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] byte_in_i = 8'd0;
  logic       chunk_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] byte_out_o;
  logic [2:0] byte_kind_o;
  logic [2:0] event_res_o;
  logic [7:0] name_length_o;
  logic       chunk_end_o;

  markup_byte_t byte_q[$];
  token_t       token_q[$];
  scan_state_t  scan_st;
  markup_byte_t cur_byte;
  token_t       got_token;
  logic         in_fire = 1'b0;
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  cycle_cnt = 0;
  stall_mode_e  stall_mode = STALL_NONE;

  logic [7:0] value_marks [7] = '{CH_LT, CH_GT, CH_SLASH, CH_QMARK, CH_EQ, CH_SPACE, CH_SQUOTE};

  xml_markup_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .chunk_last_i  (chunk_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .byte_kind_o   (byte_kind_o),
    .event_res_o   (event_res_o),
    .name_length_o (name_length_o),
    .chunk_end_o   (chunk_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Tag-name handling; also serves '>' and '/' seen in attribute-name mode.
  function automatic scan_res_t tag_byte(logic [7:0] c);
    scan_res_t r;
    r.kind = KIND_SKIP;
    r.ev   = EV_NONE;
    r.len  = 8'd0;
    if (c == CH_SLASH) begin
      scan_st.mode = MODE_ENDTAG;
      if (scan_st.count != 8'd0) begin
        r.ev  = EV_START;
        r.len = scan_st.count;
      end
    end else if (c == CH_SPACE) begin
      scan_st.mode = MODE_ATTR;
    end else if (c == CH_GT) begin
      scan_st.mode = MODE_TEXT;
      r.ev  = EV_START;
      r.len = scan_st.count;
    end else if (c != CH_QMARK) begin
      if (scan_st.count != COUNT_MAX) scan_st.count = scan_st.count + 8'd1;
      r.kind = KIND_TAG;
    end
    return r;
  endfunction

  function automatic token_t scan_token(logic [7:0] c, logic last);
    token_t t;
    t.data     = c;
    t.last     = last;
    t.res.kind = KIND_SKIP;
    t.res.ev   = EV_NONE;
    t.res.len  = 8'd0;
    case (scan_st.mode)
      MODE_TAG: t.res = tag_byte(c);
      MODE_ATTR: begin
        if (c == CH_GT || c == CH_SLASH) t.res = tag_byte(c);
        else if (c == CH_SQUOTE) scan_st.mode = MODE_VALSQ;
        else if (c == CH_DQUOTE) scan_st.mode = MODE_VALDQ;
        else if (c != CH_QMARK && c != CH_SPACE && c != CH_EQ) t.res.kind = KIND_ATTR;
      end
      MODE_VALSQ, MODE_VALDQ: begin
        if (c == ((scan_st.mode == MODE_VALSQ) ? CH_SQUOTE : CH_DQUOTE)) begin
          scan_st.mode = MODE_ATTR;
          t.res.ev = EV_ATTR;
        end else begin
          t.res.kind = KIND_VAL;
        end
      end
      MODE_ENDTAG: begin
        if (c == CH_GT) begin
          scan_st.mode = MODE_TEXT;
          t.res.ev  = EV_END;
          t.res.len = scan_st.count;
        end else if (c != CH_SPACE) begin
          if (scan_st.count != COUNT_MAX) scan_st.count = scan_st.count + 8'd1;
          t.res.kind = KIND_ENDTAG;
        end
      end
      default: begin
        if (c == CH_LT) begin
          scan_st.mode = MODE_TAG;
          if (scan_st.pending) t.res.ev = EV_TEXT;
          scan_st.pending = 1'b0;
          scan_st.count = 8'd0;
        end else begin
          scan_st.mode = MODE_TEXT;
          scan_st.pending = 1'b1;
          t.res.kind = KIND_TEXT;
        end
      end
    endcase
    return t;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("t=%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      scan_st.mode    = MODE_TEXT;
      scan_st.pending = 1'b0;
      scan_st.count   = 8'd0;
      in_fire <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $display("t=%0t: unexpected result, byte_out %0d", $time, byte_out_o);
          errors++;
        end else begin
          got_token = token_q.pop_front();
          check_field("byte_out", got_token.data, byte_out_o);
          check_field("byte_kind", got_token.res.kind, byte_kind_o);
          check_field("event_res", got_token.res.ev, event_res_o);
          check_field("name_length", got_token.res.len, name_length_o);
          check_field("chunk_end", got_token.last, chunk_end_o);
        end
      end
      if (in_valid_i && !in_stall_o) token_q.push_back(scan_token(byte_in_i, chunk_last_i));
      in_fire <= in_valid_i && !in_stall_o;
    end

    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0 && !(byte_q[0].drain && token_q.size() != 0)) begin
        cur_byte = byte_q.pop_front();
        byte_in_i    <= cur_byte.data;
        chunk_last_i <= cur_byte.last;
        in_valid_i   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switch at random between stall patterns: none, half, heavy and toggling.
  always @(negedge clk_i) begin
    cycle_cnt++;
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_HALF:   out_stall_i <= $urandom_range(0, 1) == 0;
      STALL_HEAVY:  out_stall_i <= $urandom_range(0, 3) != 0;
      default:      out_stall_i <= cycle_cnt[0];
    endcase
  end

  task automatic put_byte(logic [7:0] c);
    markup_byte_t b;
    b.data  = c;
    b.last  = $urandom_range(0, 7) == 0;
    b.drain = $urandom_range(0, 149) == 0;
    byte_q.push_back(b);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_LT || c == CH_GT || c == CH_SLASH || c == CH_QMARK || c == CH_EQ ||
           c == CH_SPACE || c == CH_SQUOTE || c == CH_DQUOTE)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic put_name(int unsigned n);
    repeat (n) put_byte(($urandom_range(0, 7) == 0) ? CH_QMARK : plain_byte());
  endtask

  // Append one markup fragment: mostly well-formed tags and text, some noise.
  task automatic put_fragment();
    int unsigned pick;
    logic [7:0]  quote;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 6)) put_byte(plain_byte());
    end else if (pick < 65) begin
      put_byte(CH_LT);
      put_name($urandom_range(0, 8));
      repeat ($urandom_range(0, 3)) begin
        put_byte(CH_SPACE);
        put_name($urandom_range(1, 5));
        if ($urandom_range(0, 4) == 0) put_byte(CH_SPACE);
        put_byte(CH_EQ);
        if ($urandom_range(0, 4) == 0) put_byte(CH_SPACE);
        quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        put_byte(quote);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            if (quote == CH_SQUOTE) put_byte(value_marks[$urandom_range(0, 5)]);
            else put_byte(value_marks[$urandom_range(0, 6)]);
          end else begin
            put_byte(plain_byte());
          end
        end
        // leave a value open now and then
        if ($urandom_range(0, 7) != 0) put_byte(quote);
      end
      if ($urandom_range(0, 5) == 0) begin
        put_byte(CH_SPACE);
        put_name($urandom_range(1, 4));
      end
      if ($urandom_range(0, 2) == 0) put_byte(CH_SLASH);
      put_byte(CH_GT);
    end else if (pick < 88) begin
      put_byte(CH_LT);
      put_byte(CH_SLASH);
      put_name($urandom_range(0, 8));
      if ($urandom_range(0, 3) == 0) put_byte(CH_SPACE);
      put_byte(CH_GT);
    end else begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned base;

    // Directed: question marks, quotes of both kinds, slash and bracket in
    // attribute mode, empty names, spaces in end tags, byte extremes.
    put_byte(8'h00);
    put_str("<a? b?='\"'c=\"'\"/>");
    put_byte(8'hFF);
    put_str("</ z><><q r></>");
    byte_q[$].drain = 1'b1;

    base = byte_q.size();
    while (byte_q.size() - base < 60) put_fragment();

    // Saturate the name count in the tag name and carry it through a self-closing tag.
    put_byte(CH_LT);
    repeat (258) put_byte(plain_byte());
    put_byte(CH_SLASH);
    repeat (3) put_byte(plain_byte());
    put_byte(CH_GT);

    base = byte_q.size();
    while (byte_q.size() - base < 70) put_fragment();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/xmt_pkg.sv
hw/rtl/xmt_scan.sv
hw/rtl/xml_markup_tokenizer.sv
hw/rtl/xmt_chk.sv
bench/tb.sv
